// ----- rtl/dsa_pkg.sv -----
`default_nettype none
package dsa_pkg;

  localparam int ValW = 32;
  localparam int QDepth = 2;

  typedef struct packed {
    logic              last;
    logic              compare;
    logic              test_bad;
    logic              ref_bad;
    logic signed [31:0] test_value;
    logic signed [31:0] ref_value;
    logic [32:0]       diff;
    logic [15:0]       source_index;
    logic [7:0]        level_index;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [32:0] diff;
    logic [31:0] denom;
  } div_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_UPDATE
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/dsa_front.sv -----
`default_nettype none
module dsa_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  test_value,
  input  wire logic signed [31:0]  ref_value,
  input  wire logic                test_valid,
  input  wire logic                ref_valid,
  input  wire logic [15:0]         source_index,
  input  wire logic [7:0]          level_index,
  input  wire logic                last,
  output logic                     q_valid,
  input  wire logic                q_pop,
  output dsa_pkg::item_t           q_item
);

  dsa_pkg::item_t mem_r [dsa_pkg::QDepth];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  dsa_pkg::item_t it;
  logic signed [32:0] d;
  logic push;

  always_comb begin
    d = {test_value[31], test_value} - {ref_value[31], ref_value};
    it.last = last;
    it.test_bad = !test_valid;
    it.ref_bad = test_valid && !ref_valid;
    it.compare = test_valid && ref_valid;
    it.test_value = test_value;
    it.ref_value = ref_value;
    it.diff = d[32] ? 33'(-d) : 33'(d);
    it.source_index = source_index;
    it.level_index = level_index;
  end

  assign in_ready = cnt_r != 2'(dsa_pkg::QDepth);
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != 2'd0;
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= it;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dsa_divider.sv -----
`default_nettype none
module dsa_divider (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  dsa_pkg::div_req_t req,
  output logic            done,
  output logic [31:0]     quotient
);

  logic [48:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] trial;
  logic        ovf;

  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r, num_r[48]} - {2'b0, den_r};
    if (busy_r) begin
      num_nxt = {num_r[47:0], !trial[33]};
      rem_nxt = trial[33] ? {rem_r[31:0], num_r[48]} : trial[32:0];
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
    ovf = num_r[48:32] != 17'd0;
  end

  assign done = !busy_r && cnt_r == 6'd0;
  assign quotient = ovf ? 32'hFFFF_FFFF : num_r[31:0];

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= {req.diff, 16'd0};
      rem_r <= 33'd0;
      den_r <= req.denom;
    end else begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 6'd0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd49;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dsa_back.sv -----
`default_nettype none
module dsa_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  dsa_pkg::item_t   q_item,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [383:0]     out_tdata
);

  dsa_pkg::back_state_t st_r, st_nxt;
  dsa_pkg::div_req_t    req;
  logic        div_done;
  logic [31:0] quot;
  logic [31:0] cnt_r, tbad_r, rbad_r, pabs_r, prel_r;
  logic signed [31:0] tlo_r, thi_r, rlo_r, rhi_r;
  logic [63:0] ssum_r, sq_r;
  logic signed [16:0] psrc_r;
  logic signed [8:0]  plev_r;
  logic [31:0] cnt_nxt, tbad_nxt, rbad_nxt, pabs_nxt, prel_nxt;
  logic signed [31:0] tlo_nxt, thi_nxt, rlo_nxt, rhi_nxt;
  logic [63:0] ssum_nxt;
  logic signed [16:0] psrc_nxt;
  logic signed [8:0]  plev_nxt;
  logic [31:0] dclip;
  logic [64:0] sadd;
  logic ov_pending;
  logic [383:0] snap;

  dsa_divider u_div (.clk(clk), .rst_n(rst_n), .req(req), .done(div_done), .quotient(quot));

  assign dclip = q_item.diff[32] ? 32'hFFFF_FFFF : q_item.diff[31:0];
  assign sadd = {1'b0, ssum_r} + {1'b0, sq_r};
  assign ov_pending = out_tvalid && !out_tready;

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    req.start = 1'b0;
    req.diff = q_item.diff;
    req.denom = (q_item.ref_value == 32'sd0) ? 32'd1 :
                (q_item.ref_value[31] ? 32'(-q_item.ref_value) : 32'(q_item.ref_value));
    unique case (st_r)
      dsa_pkg::ST_IDLE: begin
        if (q_valid && !(ov_pending && q_item.last)) begin
          if (q_item.compare) begin
            req.start = 1'b1;
            st_nxt = dsa_pkg::ST_DIV;
          end else begin
            q_pop = 1'b1;
          end
        end
      end
      dsa_pkg::ST_DIV: if (div_done) st_nxt = dsa_pkg::ST_SQ;
      dsa_pkg::ST_SQ: st_nxt = dsa_pkg::ST_UPDATE;
      dsa_pkg::ST_UPDATE: begin
        q_pop = 1'b1;
        st_nxt = dsa_pkg::ST_IDLE;
      end
      default: st_nxt = dsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    tbad_nxt = tbad_r;
    rbad_nxt = rbad_r;
    tlo_nxt = tlo_r;
    thi_nxt = thi_r;
    rlo_nxt = rlo_r;
    rhi_nxt = rhi_r;
    pabs_nxt = pabs_r;
    prel_nxt = prel_r;
    ssum_nxt = ssum_r;
    psrc_nxt = psrc_r;
    plev_nxt = plev_r;
    if (q_item.test_bad && tbad_r != '1) tbad_nxt = tbad_r + 32'd1;
    if (q_item.ref_bad && rbad_r != '1) rbad_nxt = rbad_r + 32'd1;
    if (q_item.compare) begin
      if (cnt_r != '1) cnt_nxt = cnt_r + 32'd1;
      if (q_item.test_value < tlo_r) tlo_nxt = q_item.test_value;
      if (q_item.test_value > thi_r) thi_nxt = q_item.test_value;
      if (q_item.ref_value < rlo_r) rlo_nxt = q_item.ref_value;
      if (q_item.ref_value > rhi_r) rhi_nxt = q_item.ref_value;
      ssum_nxt = (q_item.diff[32] || sadd[64]) ? '1 : sadd[63:0];
      if (dclip > pabs_r) begin
        pabs_nxt = dclip;
        psrc_nxt = {1'b0, q_item.source_index};
        plev_nxt = {1'b0, q_item.level_index};
      end
      if (quot > prel_r) prel_nxt = quot;
    end
    snap = {6'd0, plev_nxt, psrc_nxt, ssum_nxt, prel_nxt, pabs_nxt, rhi_nxt, rlo_nxt,
            thi_nxt, tlo_nxt, rbad_nxt, tbad_nxt, cnt_nxt};
  end

  always_ff @(posedge clk) begin
    if (st_r == dsa_pkg::ST_DIV) sq_r <= dclip * dclip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= dsa_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (q_pop && q_item.last)) begin
      cnt_r <= '0; tbad_r <= '0; rbad_r <= '0; pabs_r <= '0; prel_r <= '0;
      tlo_r <= 32'sh7FFF_FFFF; rlo_r <= 32'sh7FFF_FFFF;
      thi_r <= 32'sh8000_0000; rhi_r <= 32'sh8000_0000;
      ssum_r <= '0; psrc_r <= -17'sd1; plev_r <= -9'sd1;
    end else if (q_pop) begin
      cnt_r <= cnt_nxt;
      tbad_r <= tbad_nxt;
      rbad_r <= rbad_nxt;
      tlo_r <= tlo_nxt;
      thi_r <= thi_nxt;
      rlo_r <= rlo_nxt;
      rhi_r <= rhi_nxt;
      pabs_r <= pabs_nxt;
      prel_r <= prel_nxt;
      ssum_r <= ssum_nxt;
      psrc_r <= psrc_nxt;
      plev_r <= plev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (q_pop && q_item.last) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) out_tdata <= snap;
  end

endmodule
`default_nettype wire

// ----- rtl/difference_statistics_accumulator.sv -----
`default_nettype none
// Accumulates difference statistics over runs of Q16.16 test/reference pairs and emits one
// totals transaction on the pair marked tlast. A compared pair holds the accumulator while the
// bit-serial relative-difference divider (49 steps) runs; a skipped pair is popped with no divide.
// A two-entry queue decouples the input from the accumulator, and the totals register lets
// the next run start while the result still waits.
module difference_statistics_accumulator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // test_value[31:0], ref_value[63:32], test_valid[64], ref_valid[65],
  // source_index[81:66], level_index[89:82], zero fill
  input  wire logic [95:0]  in_tdata,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pair_count[31:0], test_bad_count[63:32], ref_bad_count[95:64], test_minimum[127:96],
  // test_maximum[159:128], ref_minimum[191:160], ref_maximum[223:192],
  // largest_abs_diff[255:224], largest_rel_diff[287:256], sum_sq_diff[351:288],
  // worst_source[368:352], worst_level[377:369], zero fill
  output logic [383:0]      out_tdata
);

  logic           q_valid, q_pop;
  dsa_pkg::item_t q_item;

  dsa_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .test_value(in_tdata[31:0]), .ref_value(in_tdata[63:32]),
    .test_valid(in_tdata[64]), .ref_valid(in_tdata[65]),
    .source_index(in_tdata[81:66]), .level_index(in_tdata[89:82]), .last(in_tlast),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  dsa_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  a_pop_needs_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(q_pop && q_item.last))
    else $error("result overwritten");

endmodule
`default_nettype wire
